// ----- design/skfk_pkg.sv -----
// skfk_pkg: shared types, codes and arithmetic helpers for skeleton_forward_kinematics.
// No dependencies; used by skfk_ctrl, skfk_dpath and the top level.
package skfk_pkg;

    // input item function codes
    localparam logic [1:0] FUNC_LOAD_TP = 2'd0;
    localparam logic [1:0] FUNC_LOAD_IB = 2'd1;
    localparam logic [1:0] FUNC_POSE    = 2'd2;

    // quaternion part positions
    localparam logic [1:0] QX = 2'd0;
    localparam logic [1:0] QY = 2'd1;
    localparam logic [1:0] QZ = 2'd2;
    localparam logic [1:0] QW = 2'd3;

    localparam int ACC_W = 36;
    localparam logic signed [ACC_W-1:0] HALF_Q8  = 36'sd128;
    localparam logic signed [ACC_W-1:0] HALF_Q20 = 36'sd524288;
    localparam logic signed [ACC_W-1:0] ONE_Q28  = 36'sd268435456;
    localparam logic signed [ACC_W-1:0] SAT_HI   = 36'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_LO   = -36'sd32768;
    localparam logic signed [15:0]      ONE_Q8   = 16'sd256;

    typedef enum logic [1:0] {
        OP_ROT = 2'd0,
        OP_TP  = 2'd1,
        OP_PW  = 2'd2,
        OP_SK  = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [1:0] r;
        logic [1:0] k;
        logic       out_fire;
        logic [1:0] out_row;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pose_ok;
    } sts_t;

    typedef struct packed {
        logic [1:0] pa;
        logic [1:0] pb;
        logic       neg;
    } rterm_t;

    function automatic logic signed [15:0] elem16(input logic [63:0] d, input logic [1:0] c);
        return d[16*c +: 16];
    endfunction

    // round half up by 8 or 20 bits, then saturate to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] v,
                                                   input logic wide);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] sh;
        t  = v + (wide ? HALF_Q20 : HALF_Q8);
        sh = wide ? (t >>> 20) : (t >>> 8);
        if (sh > SAT_HI)
            return 16'sh7fff;
        else if (sh < SAT_LO)
            return 16'sh8000;
        else
            return sh[15:0];
    endfunction

    // rotation entry term (row, col, step): each entry is two doubled products
    function automatic rterm_t rot_term(input logic [1:0] r, input logic [1:0] c,
                                        input logic k);
        rterm_t t;
        t = '{pa: QX, pb: QX, neg: 1'b0};
        case ({r, c, k})
            {2'd0, 2'd0, 1'b0}: t = '{pa: QY, pb: QY, neg: 1'b1};
            {2'd0, 2'd0, 1'b1}: t = '{pa: QZ, pb: QZ, neg: 1'b1};
            {2'd0, 2'd1, 1'b0}: t = '{pa: QX, pb: QY, neg: 1'b0};
            {2'd0, 2'd1, 1'b1}: t = '{pa: QZ, pb: QW, neg: 1'b0};
            {2'd0, 2'd2, 1'b0}: t = '{pa: QX, pb: QZ, neg: 1'b0};
            {2'd0, 2'd2, 1'b1}: t = '{pa: QY, pb: QW, neg: 1'b1};
            {2'd1, 2'd0, 1'b0}: t = '{pa: QX, pb: QY, neg: 1'b0};
            {2'd1, 2'd0, 1'b1}: t = '{pa: QZ, pb: QW, neg: 1'b1};
            {2'd1, 2'd1, 1'b0}: t = '{pa: QX, pb: QX, neg: 1'b1};
            {2'd1, 2'd1, 1'b1}: t = '{pa: QZ, pb: QZ, neg: 1'b1};
            {2'd1, 2'd2, 1'b0}: t = '{pa: QY, pb: QZ, neg: 1'b0};
            {2'd1, 2'd2, 1'b1}: t = '{pa: QX, pb: QW, neg: 1'b0};
            {2'd2, 2'd0, 1'b0}: t = '{pa: QX, pb: QZ, neg: 1'b0};
            {2'd2, 2'd0, 1'b1}: t = '{pa: QY, pb: QW, neg: 1'b0};
            {2'd2, 2'd1, 1'b0}: t = '{pa: QY, pb: QZ, neg: 1'b0};
            {2'd2, 2'd1, 1'b1}: t = '{pa: QX, pb: QW, neg: 1'b1};
            {2'd2, 2'd2, 1'b0}: t = '{pa: QX, pb: QX, neg: 1'b1};
            {2'd2, 2'd2, 1'b1}: t = '{pa: QY, pb: QY, neg: 1'b1};
            default:            t = '{pa: QX, pb: QX, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

// ----- design/skfk_ctrl.sv -----
// skfk_ctrl: sequencer for pose items (rotation, three matrix products, row output).
// Depends on skfk_pkg; drives skfk_dpath through cmd_t.
module skfk_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_out_row,
    output logic                m_last,
    input  skfk_pkg::sts_t      sts,
    output skfk_pkg::cmd_t      cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ROT   = 7'b0000010,
        ST_TP    = 7'b0000100,
        ST_PW    = 7'b0001000,
        ST_SK    = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] r_reg, r_next;
    logic [1:0] k_reg, k_next;
    logic       out_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_out_row = r_reg;
    assign m_last    = (r_reg == 2'd3);
    assign out_fire  = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.r      = r_reg;
        cmd.k      = k_reg;
        cmd.out_row  = r_reg;
        cmd.out_fire = out_fire;
        unique case (state_reg)
            ST_IDLE: begin
                r_next = 2'd0;
                k_next = 2'd0;
                if (s_valid && sts.pose_ok) begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                cmd.valid = 1'b1;
                cmd.op    = skfk_pkg::OP_ROT;
                if (k_reg == 2'd1) begin
                    k_next = 2'd0;
                    if (r_reg == 2'd2) begin
                        r_next     = 2'd0;
                        state_next = ST_TP;
                    end else begin
                        r_next = r_reg + 2'd1;
                    end
                end else begin
                    k_next = 2'd1;
                end
            end
            ST_TP, ST_PW, ST_SK: begin
                cmd.valid = 1'b1;
                cmd.op    = (state_reg == ST_TP) ? skfk_pkg::OP_TP :
                            (state_reg == ST_PW) ? skfk_pkg::OP_PW : skfk_pkg::OP_SK;
                k_next    = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    r_next = r_reg + 2'd1;
                    if (r_reg == 2'd3) begin
                        state_next = (state_reg == ST_TP) ? ST_PW :
                                     (state_reg == ST_PW) ? ST_SK : ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // last skin MAC lands this cycle
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) begin
                    r_next = r_reg + 2'd1;
                    if (r_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_reg     <= 2'd0;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready && !cmd.valid)
        else $error("result beat offered while input open or datapath busy");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && sts.pose_ok) |=> !s_ready && cmd.valid)
        else $error("pose item accepted without starting sequence");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("block not idle after last beat");
`endif

endmodule

// ----- design/skfk_dpath.sv -----
// skfk_dpath: bind/world memories, four MAC lanes and result matrices.
// Depends on skfk_pkg; sequenced by skfk_ctrl.
module skfk_dpath #(
    parameter int MAX_BONES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  logic                in_fire,
    input  logic [1:0]          s_func,
    input  logic [5:0]          s_bone,
    input  logic [1:0]          s_row,
    input  logic [63:0]         s_row_data,
    input  logic [5:0]          s_parent,
    input  logic                s_is_root,
    input  logic [63:0]         s_quat,
    input  skfk_pkg::cmd_t      cmd,
    output skfk_pkg::sts_t      sts,
    output logic [5:0]          m_out_bone,
    output logic [63:0]         m_world_row,
    output logic [63:0]         m_skin_row
);

    localparam int DEPTH = 4 * MAX_BONES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_BONES);
    localparam int W     = skfk_pkg::ACC_W;

    logic [63:0] tp_mem [DEPTH];
    logic [63:0] ib_mem [DEPTH];
    logic [63:0] wd_mem [DEPTH];
    logic [6:0]  pt_mem [MAX_BONES];

    logic [6:0]  count_reg;
    logic [5:0]  bone_reg;
    logic [63:0] quat_reg;
    logic [63:0] tp_q, ib_q, wd_q;
    logic [6:0]  pt_q;
    skfk_pkg::cmd_t cmd_q;

    logic signed [15:0] rot_reg [3][3];
    logic signed [15:0] t_reg   [4][4];
    logic signed [15:0] w_reg   [4][4];
    logic signed [15:0] s_reg   [4][4];
    logic signed [W-1:0] acc_reg [4];

    logic        bone_in_range;
    logic        wr_ok;
    logic [AW-1:0] in_addr, tp_ra, ib_ra, wd_ra, wd_wa;
    logic        pw_zero;

    assign bone_in_range = (32'(s_bone) < MAX_BONES);
    assign wr_ok         = in_fire && bone_in_range;
    assign sts.pose_ok   = (s_func == skfk_pkg::FUNC_POSE) && bone_in_range
                           && ({1'b0, s_bone} < count_reg);

    assign in_addr = AW'({s_bone, s_row});
    assign tp_ra   = AW'({bone_reg, cmd.k});
    assign ib_ra   = AW'({bone_reg, cmd.r});
    assign wd_ra   = AW'({pt_q[5:0], cmd.k});
    assign wd_wa   = AW'({bone_reg, cmd.out_row});
    assign pw_zero = (32'(pt_q[5:0]) >= MAX_BONES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 7'd0;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok && s_func == skfk_pkg::FUNC_LOAD_TP) begin
            tp_mem[in_addr] <= s_row_data;
            pt_mem[BW'(s_bone)] <= {s_is_root, s_parent};
        end
        if (wr_ok && s_func == skfk_pkg::FUNC_LOAD_IB) begin
            ib_mem[in_addr] <= s_row_data;
        end
        if (cmd.out_fire) begin
            wd_mem[wd_wa] <= {w_reg[cmd.out_row][3], w_reg[cmd.out_row][2],
                              w_reg[cmd.out_row][1], w_reg[cmd.out_row][0]};
        end
        tp_q <= tp_mem[tp_ra];
        ib_q <= ib_mem[ib_ra];
        wd_q <= wd_mem[wd_ra];
        pt_q <= pt_mem[BW'(bone_reg)];
        if (in_fire) begin
            bone_reg <= s_bone;
            quat_reg <= s_quat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_q <= '0;
        end else begin
            cmd_q <= cmd;
        end
    end

    // MAC lanes: lane c builds column c of the current row
    logic signed [15:0]  op_a [4];
    logic signed [15:0]  op_b [4];
    logic signed [31:0]  prod [4];
    logic signed [W-1:0] term [4];
    logic signed [W-1:0] init [4];
    logic signed [W-1:0] sum  [4];
    logic                fin;
    skfk_pkg::rterm_t    rt   [4];

    always_comb begin
        fin = cmd_q.valid && ((cmd_q.op == skfk_pkg::OP_ROT) ? (cmd_q.k == 2'd1)
                                                             : (cmd_q.k == 2'd3));
        for (int c = 0; c < 4; c++) begin
            rt[c]   = skfk_pkg::rot_term(cmd_q.r, 2'(c), cmd_q.k[0]);
            op_a[c] = '0;
            op_b[c] = '0;
            case (cmd_q.op)
                skfk_pkg::OP_ROT: begin
                    op_a[c] = skfk_pkg::elem16(quat_reg, rt[c].pa);
                    op_b[c] = skfk_pkg::elem16(quat_reg, rt[c].pb);
                end
                skfk_pkg::OP_TP: begin
                    if (cmd_q.r == 2'd3)
                        op_a[c] = (cmd_q.k == 2'd3) ? skfk_pkg::ONE_Q8 : 16'sd0;
                    else if (cmd_q.k == 2'd3)
                        op_a[c] = 16'sd0;
                    else
                        op_a[c] = rot_reg[cmd_q.r][cmd_q.k];
                    op_b[c] = skfk_pkg::elem16(tp_q, 2'(c));
                end
                skfk_pkg::OP_PW: begin
                    op_a[c] = t_reg[cmd_q.r][cmd_q.k];
                    // root: multiply by identity, which leaves T exact
                    if (pt_q[6])
                        op_b[c] = (2'(c) == cmd_q.k) ? skfk_pkg::ONE_Q8 : 16'sd0;
                    else if (pw_zero)
                        op_b[c] = 16'sd0;
                    else
                        op_b[c] = skfk_pkg::elem16(wd_q, 2'(c));
                end
                default: begin
                    op_a[c] = skfk_pkg::elem16(ib_q, cmd_q.k);
                    op_b[c] = w_reg[cmd_q.k][c];
                end
            endcase
            prod[c] = op_a[c] * op_b[c];
            if (cmd_q.op == skfk_pkg::OP_ROT) begin
                term[c] = rt[c].neg ? -(W'(prod[c]) <<< 1) : (W'(prod[c]) <<< 1);
                if (cmd_q.k == 2'd0)
                    init[c] = (2'(c) == cmd_q.r) ? skfk_pkg::ONE_Q28 : '0;
                else
                    init[c] = acc_reg[c];
            end else begin
                term[c] = W'(prod[c]);
                init[c] = (cmd_q.k == 2'd0) ? '0 : acc_reg[c];
            end
            sum[c] = init[c] + term[c];
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            if (cmd_q.valid) begin
                acc_reg[c] <= sum[c];
            end
            if (fin) begin
                case (cmd_q.op)
                    skfk_pkg::OP_ROT: begin
                        if (c < 3 && cmd_q.r != 2'd3)
                            rot_reg[cmd_q.r][c] <= skfk_pkg::rnd_sat(sum[c], 1'b1);
                    end
                    skfk_pkg::OP_TP: t_reg[cmd_q.r][c] <= skfk_pkg::rnd_sat(sum[c], 1'b0);
                    skfk_pkg::OP_PW: w_reg[cmd_q.r][c] <= skfk_pkg::rnd_sat(sum[c], 1'b0);
                    default:         s_reg[cmd_q.r][c] <= skfk_pkg::rnd_sat(sum[c], 1'b0);
                endcase
            end
        end
    end

    assign m_out_bone  = bone_reg;
    assign m_world_row = {w_reg[cmd.out_row][3], w_reg[cmd.out_row][2],
                          w_reg[cmd.out_row][1], w_reg[cmd.out_row][0]};
    assign m_skin_row  = {s_reg[cmd.out_row][3], s_reg[cmd.out_row][2],
                          s_reg[cmd.out_row][1], s_reg[cmd.out_row][0]};

endmodule

// ----- design/skeleton_forward_kinematics.sv -----
// skeleton_forward_kinematics: top level, bone world and skinning matrix palette.
// Depends on skfk_pkg, skfk_ctrl, skfk_dpath.
//
//   channel  | handshake          | beat
//   s_       | s_valid / s_ready  | load row or pose quaternion for one bone
//   m_       | m_valid / m_ready  | one world row and skin row, m_last on row 3
//   cfg_     | cfg_we             | bone_count, no back-pressure
//
// Load items are taken while idle. A pose item runs the rotation, then the three
// 4x4 products on four MAC lanes, a drain state, then four beats that m_ready can
// stall. The shared lanes and the single read port of each row memory keep the work
// serial. s_ready is low from pose accept until the last beat is taken. Reset
// (aresetn, synchronous) clears control and bone_count only.
module skeleton_forward_kinematics #(
    parameter int MAX_BONES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [5:0]  s_bone,
    input  logic [1:0]  s_row,
    input  logic [63:0] s_row_data,
    input  logic [5:0]  s_parent,
    input  logic        s_is_root,
    input  logic [63:0] s_quat,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_out_bone,
    output logic [1:0]  m_out_row,
    output logic [63:0] m_world_row,
    output logic [63:0] m_skin_row,
    output logic        m_last
);

    skfk_pkg::cmd_t cmd;
    skfk_pkg::sts_t sts;

    skfk_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_row (m_out_row),
        .m_last    (m_last),
        .sts       (sts),
        .cmd       (cmd)
    );

    skfk_dpath #(
        .MAX_BONES (MAX_BONES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_fire     (s_valid && s_ready),
        .s_func      (s_func),
        .s_bone      (s_bone),
        .s_row       (s_row),
        .s_row_data  (s_row_data),
        .s_parent    (s_parent),
        .s_is_root   (s_is_root),
        .s_quat      (s_quat),
        .cmd         (cmd),
        .sts         (sts),
        .m_out_bone  (m_out_bone),
        .m_world_row (m_world_row),
        .m_skin_row  (m_skin_row)
    );

endmodule

// ----- bench/tb_skeleton_forward_kinematics.sv -----
// Testbench for skeleton_forward_kinematics: random and directed load/pose beats,
// in-bench bone matrix predictor, scoreboard on world and skin rows. Needs skfk_pkg.
module tb_skeleton_forward_kinematics;

    localparam int NB = 64;
    // unused function code, must be dropped by the block
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  bone;
        logic [1:0]  row;
        logic [63:0] row_data;
        logic [5:0]  parent;
        logic        is_root;
        logic [63:0] quat;
    } beat_t;

    typedef struct packed {
        logic [5:0]  bone;
        logic [1:0]  row;
        logic [63:0] world;
        logic [63:0] skin;
        logic        last;
    } row_t;

    typedef longint mat_t [4][4];

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [6:0]  cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_func = 0;
    logic [5:0]  s_bone = 0;
    logic [1:0]  s_row = 0;
    logic [63:0] s_row_data = 0;
    logic [5:0]  s_parent = 0;
    logic        s_is_root = 0;
    logic [63:0] s_quat = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [5:0]  m_out_bone;
    logic [1:0]  m_out_row;
    logic [63:0] m_world_row;
    logic [64-1:0] m_skin_row;
    logic        m_last;

    skeleton_forward_kinematics dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_bone(s_bone),
        .s_row(s_row), .s_row_data(s_row_data), .s_parent(s_parent),
        .s_is_root(s_is_root), .s_quat(s_quat), .m_valid(m_valid), .m_ready(m_ready),
        .m_out_bone(m_out_bone), .m_out_row(m_out_row), .m_world_row(m_world_row),
        .m_skin_row(m_skin_row), .m_last(m_last)
    );

    // predictor state
    logic [63:0] tp_mem [4*NB];
    logic [63:0] ib_mem [4*NB];
    logic [63:0] world_mem [4*NB];
    logic [6:0]  parent_mem [NB];
    int unsigned bones_live;
    // stimulus-side tracking so no unwritten entry is ever read
    bit tp_done [NB][4];
    bit ib_done [NB][4];
    bit world_done [NB];

    beat_t pending_beats [$];
    row_t  expected_rows [$];
    int    errors = 0;
    bit    drain_hold = 0;
    bit    s_taken = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint el(input logic [63:0] d, input int c);
        return longint'($signed(d[16*c +: 16]));
    endfunction

    function automatic longint rnd(input longint v, input int s);
        longint t;
        t = v + (longint'(1) << (s - 1));
        t = t >>> s;
        if (t > 32767) return 32767;
        if (t < -32768) return -32768;
        return t;
    endfunction

    function automatic void mmul(input mat_t a, input mat_t b, output mat_t o);
        longint acc;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += a[r][k] * b[k][c];
                o[r][c] = rnd(acc, 8);
            end
    endfunction

    function automatic void fetch(input logic [63:0] mem [4*NB], input int base,
                                  output mat_t m);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) m[r][c] = el(mem[base + r], c);
    endfunction

    function automatic logic [63:0] pack(input mat_t m, input int r);
        logic [63:0] d;
        for (int c = 0; c < 4; c++) d[16*c +: 16] = m[r][c][15:0];
        return d;
    endfunction

    function automatic void quat_rotation(input logic [63:0] q, output mat_t m);
        longint x, y, z, w, f [3][3], one;
        x = el(q, 0); y = el(q, 1); z = el(q, 2); w = el(q, 3);
        one = longint'(1) << 28;
        f[0][0] = one - 2 * (y * y + z * z); f[0][1] = 2 * (x * y + z * w);
        f[0][2] = 2 * (x * z - y * w);       f[1][0] = 2 * (x * y - z * w);
        f[1][1] = one - 2 * (x * x + z * z); f[1][2] = 2 * (y * z + x * w);
        f[2][0] = 2 * (x * z + y * w);       f[2][1] = 2 * (y * z - x * w);
        f[2][2] = one - 2 * (x * x + y * y);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) m[r][c] = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) m[r][c] = rnd(f[r][c], 20);
        m[3][3] = 256;
    endfunction

    // apply one accepted beat, queue the world/skin rows it yields
    function automatic void predict_bone(input beat_t b);
        mat_t rot, tp, t, pw, wm, ib, sk;
        row_t e;
        if (b.func == skfk_pkg::FUNC_LOAD_TP) begin
            tp_mem[b.bone*4 + b.row] = b.row_data;
            parent_mem[b.bone] = {b.is_root, b.parent};
        end else if (b.func == skfk_pkg::FUNC_LOAD_IB) begin
            ib_mem[b.bone*4 + b.row] = b.row_data;
        end else if (b.func == skfk_pkg::FUNC_POSE && b.bone < bones_live) begin
            quat_rotation(b.quat, rot);
            fetch(tp_mem, b.bone*4, tp);
            mmul(rot, tp, t);
            if (parent_mem[b.bone][6]) wm = t;
            else begin
                fetch(world_mem, parent_mem[b.bone][5:0]*4, pw);
                mmul(t, pw, wm);
            end
            fetch(ib_mem, b.bone*4, ib);
            mmul(ib, wm, sk);
            for (int r = 0; r < 4; r++) begin
                world_mem[b.bone*4 + r] = pack(wm, r);
                e.bone = b.bone; e.row = r[1:0];
                e.world = pack(wm, r); e.skin = pack(sk, r);
                e.last = (r == 3);
                expected_rows = {expected_rows, e};
            end
        end
    endfunction

    // input accept, seen at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            predict_bone({s_func, s_bone, s_row, s_row_data, s_parent, s_is_root,
                          s_quat});
        s_taken <= aresetn && s_valid && s_ready;
    end

    // driver
    int s_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken)
                s_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            if (!s_valid || s_taken) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 0;
                end else if (pending_beats.size() > 0 && !drain_hold) begin
                    beat_t b;
                    b = pending_beats.pop_front();
                    s_valid <= 1;
                    {s_func, s_bone, s_row, s_row_data, s_parent, s_is_root, s_quat} <= b;
                end else s_valid <= 0;
            end
        end
    end

    // sampled state for the monitor, ready toggled on falling edge
    int m_gap = 0;
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap--;
            m_ready <= 0;
        end else m_ready <= 1;
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            row_t e;
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row bone %0d row %0d", $time, m_out_bone,
                         m_out_row);
                errors++;
            end else begin
                e = expected_rows.pop_front();
                if (e.bone !== m_out_bone) begin
                    $display("%0t: bone exp %0d got %0d", $time, e.bone, m_out_bone);
                    errors++;
                end
                if (e.row !== m_out_row) begin
                    $display("%0t: row exp %0d got %0d", $time, e.row, m_out_row);
                    errors++;
                end
                if (e.world !== m_world_row) begin
                    $display("%0t: world exp %h got %h", $time, e.world, m_world_row);
                    errors++;
                end
                if (e.skin !== m_skin_row) begin
                    $display("%0t: skin exp %h got %h", $time, e.skin, m_skin_row);
                    errors++;
                end
                if (e.last !== m_last) begin
                    $display("%0t: last exp %0b got %0b", $time, e.last, m_last);
                    errors++;
                end
            end
            m_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Q7.8 row near identity, or fully random
    function automatic logic [63:0] mat_row(input int r, input bit wild);
        logic [63:0] d;
        if (wild) return rand64();
        for (int c = 0; c < 4; c++)
            d[16*c +: 16] = (c == r ? 16'sd256 : 16'sd0) + 16'($signed($urandom_range(0, 160)) - 80);
        return d;
    endfunction

    function automatic logic [63:0] unit_quat();
        logic [63:0] q;
        for (int c = 0; c < 4; c++) q[16*c +: 16] = 16'($signed($urandom_range(0, 16384)) - 8192);
        return q;
    endfunction

    function automatic beat_t mk(input logic [1:0] f, input int bone, input int row,
                                 input logic [63:0] d, input int par, input bit root,
                                 input logic [63:0] q);
        beat_t b;
        b.func = f; b.bone = 6'(bone); b.row = 2'(row); b.row_data = d;
        b.parent = 6'(par); b.is_root = root; b.quat = q;
        return b;
    endfunction

    // queue full bind data for a bone, parent chosen among already posed bones
    task automatic load_bone(input int bone, input bit root, input int par, input bit wild);
        for (int r = 0; r < 4; r++) begin
            pending_beats = {pending_beats, mk(skfk_pkg::FUNC_LOAD_TP, bone, r,
                                               mat_row(r, wild), par, root, rand64())};
            pending_beats = {pending_beats, mk(skfk_pkg::FUNC_LOAD_IB, bone, r,
                                               mat_row(r, wild), $urandom_range(0, 63),
                                               1'($urandom_range(0, 1)), rand64())};
            tp_done[bone][r] = 1; ib_done[bone][r] = 1;
        end
    endtask

    function automatic bit ready_bone(input int b);
        for (int r = 0; r < 4; r++) if (!tp_done[b][r] || !ib_done[b][r]) return 0;
        return 1;
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() > 0 || s_valid || expected_rows.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_count(input int n);
        @(negedge aclk);
        cfg_we <= 1; cfg_wdata <= 7'(n);
        @(negedge aclk);
        cfg_we <= 0;
        bones_live = n;
    endtask

    // parent entries used by poses in this phase, so roots/children stay legal
    int root_of [NB];

    task automatic pose(input int bone, input logic [63:0] q);
        pending_beats = {pending_beats, mk(skfk_pkg::FUNC_POSE, bone, $urandom_range(0, 3),
                                           rand64(), $urandom_range(0, 63),
                                           1'($urandom_range(0, 1)), q)};
        if (bone < bones_live) world_done[bone] = 1;
    endtask

    initial begin
        int n;
        for (int b = 0; b < NB; b++) root_of[b] = -1;
        bones_live = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: count 0 pose dropped, then small skeleton with extremes
        load_bone(0, 1, 0, 0); root_of[0] = 1;
        pose(0, unit_quat());
        pending_beats = {pending_beats, mk(FUNC_NONE, 0, 0, rand64(), 0, 0, rand64())};
        wait_idle();
        set_count(4);
        pose(0, 64'h4000_0000_0000_0000);            // identity rotation
        load_bone(1, 0, 0, 1); root_of[1] = 0;        // wild rows saturate
        pose(1, 64'h7fff_7fff_7fff_7fff);
        pose(1, 64'h8000_8000_8000_8000);
        load_bone(2, 1, 0, 0);                        // give bone 2 a world first
        pose(2, unit_quat());
        load_bone(2, 0, 2, 0); root_of[2] = 0;        // parent is itself, stale
        world_done[2] = 0;
        pose(2, 64'h0);
        load_bone(3, 0, 1, 0); root_of[3] = 0;
        pose(3, unit_quat());
        pose(5, unit_quat());                         // beyond count
        pose(63, 64'hffff_ffff_ffff_ffff);
        pending_beats = {pending_beats, mk(FUNC_NONE, 1, 3, 64'hffff_ffff_ffff_ffff, 63, 1,
                                           64'hffff_ffff_ffff_ffff)};
        wait_idle();
        drain_hold = 0;

        // random phases with changing bone counts, the extremes included
        for (int ph = 0; ph < 5; ph++) begin
            n = (ph == 0) ? 64 : (ph == 1) ? 1 : (ph == 4) ? 64 : $urandom_range(2, 40);
            set_count(n);
            for (int i = 0; i < 36; i++) begin
                int b, p;
                b = $urandom_range(0, 63);
                case ($urandom_range(0, 9))
                    0: pending_beats = {pending_beats,
                                        mk(FUNC_NONE, b, $urandom_range(0, 3), rand64(),
                                           $urandom_range(0, 63),
                                           1'($urandom_range(0, 1)), rand64())};
                    1, 2: begin
                        // reload bone as root or as child of a posed bone
                        p = $urandom_range(0, 63);
                        if (world_done[p] && $urandom_range(0, 1)) load_bone(b, 0, p,
                                                                   $urandom_range(0, 4) == 0);
                        else load_bone(b, 1, $urandom_range(0, 63), $urandom_range(0, 4) == 0);
                    end
                    default: begin
                        b = $urandom_range(0, n > 0 ? (n + 3 > 63 ? 63 : n + 3) : 3);
                        if (!ready_bone(b) || b >= n) begin
                            if (b >= n) pose(b, rand64());
                        end else
                            pose(b, $urandom_range(0, 3) == 0 ? rand64() : unit_quat());
                    end
                endcase
                if (i == 18) begin
                    // hold off until every row has drained
                    while (pending_beats.size() > 0 || s_valid || expected_rows.size() > 0)
                        @(posedge aclk);
                end
            end
            wait_idle();
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
